// ===== sv/pltok_pkg.sv =====
// Shared types, constants and character helpers for the policy-language tokenizer.
package pltok_pkg;

    // Default configuration
    localparam int KEYWORD_MAX_LEN_DEF = 8;
    localparam int POS_WIDTH_DEF       = 16;
    localparam int OFFSET_WIDTH_DEF    = 24;

    // Token value length is a fixed 16-bit saturating count
    localparam int          LEN_W   = 16;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Token kinds
    localparam logic [4:0] TK_EOF     = 5'd0;
    localparam logic [4:0] TK_STRING  = 5'd1;
    localparam logic [4:0] TK_NUMBER  = 5'd2;
    localparam logic [4:0] TK_UNKNOWN = 5'd3;
    localparam logic [4:0] TK_KW_BASE = 5'd4;
    localparam logic [4:0] TK_EQ_EQ   = 5'd21;
    localparam logic [4:0] TK_NE      = 5'd22;
    localparam logic [4:0] TK_LE      = 5'd23;
    localparam logic [4:0] TK_GE      = 5'd24;
    localparam logic [4:0] TK_LT      = 5'd25;
    localparam logic [4:0] TK_GT      = 5'd26;
    localparam logic [4:0] TK_SEMI    = 5'd27;
    localparam logic [4:0] TK_BAD_STR = 5'd28;

    // Input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_GREAT = 8'h3E;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // Scanner modes
    typedef enum logic [3:0] {
        M_SKIP,
        M_IDENT,
        M_INT,
        M_FRAC,
        M_STR,
        M_SLASH,
        M_LCOM,
        M_BCOM,
        M_BSTAR,
        M_LT,
        M_GT,
        M_EQ,
        M_BANG
    } scan_mode_t;

    // Keyword table, text right-justified, kind = TK_KW_BASE + index
    localparam int KW_COUNT    = 17;
    localparam int KW_MAX_TEXT = 8;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "ALLOW", "DENY", "ROLE", "ACTION", "ON", "RESOURCE", "WHERE", "AND",
        "OR", "NOT", "TRUE", "FALSE", "ip", "time", "mfa", "region", "tag"
    };

    localparam int KW_LEN [KW_COUNT] = '{
        5, 4, 4, 6, 2, 8, 5, 3, 2, 3, 4, 5, 2, 4, 3, 6, 3
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // word holds the first eight identifier bytes, first byte in [63:56],
    // unused bytes zero. Lengths above eight never match.
    function automatic logic [4:0] kw_kind(input logic [63:0] word, input logic [15:0] len);
        logic [4:0]  kind;
        logic [63:0] pattern;
        kind = TK_UNKNOWN;
        for (int k = 0; k < KW_COUNT; k++) begin
            pattern = KW_TEXT[k] << (8 * (KW_MAX_TEXT - KW_LEN[k]));
            if (len == 16'(KW_LEN[k]) && word == pattern) begin
                kind = TK_KW_BASE + 5'(k);
            end
        end
        return kind;
    endfunction

endpackage

// ===== sv/policy_language_tokenizer_unit.sv =====
// Streaming tokenizer for the access-policy language: byte in, tokens out.
// Pipeline: an item is registered at the input, decoded from that register and its
//   tokens are written to a 4-entry result queue that drives the token channel.
// Throughput: one byte per cycle; input stalls only while the result queue has
//   fewer than two free entries. Reset: asynchronous, active low, scanner idle
//   at line 1, column 1, offset 0, queue empty.
module policy_language_tokenizer_unit #(
    parameter int KEYWORD_MAX_LEN = pltok_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int POS_WIDTH       = pltok_pkg::POS_WIDTH_DEF,
    parameter int OFFSET_WIDTH    = pltok_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,

    // Source channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    cmd,
    input  logic [7:0]              src_byte,

    // Token channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [4:0]              tok_kind,
    output logic [POS_WIDTH-1:0]    start_line,
    output logic [POS_WIDTH-1:0]    start_column,
    output logic [OFFSET_WIDTH-1:0] value_offset,
    output logic [15:0]             value_length,
    output logic [7:0]              unknown_char,
    output logic                    last_of_run
);

    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);

    // ------------------------------------------------------------------
    // Input register: holds one item until the decode stage consumes it.
    // ------------------------------------------------------------------
    logic       in_vld_reg, in_vld_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       in_xfer;
    logic       go;             // decode stage consumes the held item

    logic [pltok_pkg::OQ_CW-1:0] count_reg, count_next;

    // Room for the worst case of two tokens from one byte
    assign go       = in_vld_reg && (count_reg <= pltok_pkg::OQ_CW'(pltok_pkg::OQ_DEPTH - 2));
    assign in_ready = !in_vld_reg || go;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
        begin
            in_vld_next = 1'b1;
        end
        else if (go)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cmd_reg  <= cmd;
            in_byte_reg <= src_byte;
        end
    end

    // ------------------------------------------------------------------
    // Scanner state
    // ------------------------------------------------------------------
    pltok_pkg::scan_mode_t mode_reg, mode_next;

    logic [POS_WIDTH-1:0]    cur_line_reg, cur_line_next;
    logic [POS_WIDTH-1:0]    cur_col_reg, cur_col_next;
    logic [OFFSET_WIDTH-1:0] cur_off_reg, cur_off_next;

    // Pending-token registers are only read while a token is open, and every
    // open is preceded by a start mark, so they need no reset.
    logic [POS_WIDTH-1:0]    tok_line_reg, tok_line_next;
    logic [POS_WIDTH-1:0]    tok_col_reg, tok_col_next;
    logic [OFFSET_WIDTH-1:0] tok_off_reg, tok_off_next;
    logic [15:0]             tok_len_reg, tok_len_next;
    logic [7:0]              ident_reg [KEYWORD_MAX_LEN];
    logic [7:0]              ident_next [KEYWORD_MAX_LEN];
    logic                    too_long_reg, too_long_next;

    logic       is_eos;
    logic [7:0] c;
    assign is_eos = (in_cmd_reg == pltok_pkg::CMD_EOS);
    assign c      = in_byte_reg;

    // Keyword lookup on the first eight identifier bytes
    logic [63:0] ident_word;
    logic [4:0]  ident_kind;

    always_comb
    begin
        for (int i = 0; i < pltok_pkg::KW_MAX_TEXT; i++)
        begin
            ident_word[63 - 8*i -: 8] = ident_reg[i];
        end
    end

    assign ident_kind = too_long_reg ? pltok_pkg::TK_UNKNOWN
                                     : pltok_pkg::kw_kind(ident_word, tok_len_reg);

    // ------------------------------------------------------------------
    // Decode: does this item close the pending token, and does the byte
    // start a fresh scan (the lone-character path)?
    // ------------------------------------------------------------------
    logic       close_v;        // pending token is emitted
    logic [4:0] close_kind;
    logic [7:0] close_uch;
    logic       close_pair;     // two-character operator, length forced to 2
    logic       restart;        // byte is rescanned from the idle mode

    always_comb
    begin
        close_v    = 1'b0;
        close_kind = pltok_pkg::TK_UNKNOWN;
        close_uch  = pltok_pkg::CH_NUL;
        close_pair = 1'b0;
        restart    = 1'b0;
        if (is_eos)
        begin
            // Flush whatever is open; comments just vanish
            close_v = 1'b1;
            case (mode_reg)
                pltok_pkg::M_IDENT: close_kind = ident_kind;
                pltok_pkg::M_INT,
                pltok_pkg::M_FRAC:  close_kind = pltok_pkg::TK_NUMBER;
                pltok_pkg::M_STR:   close_kind = pltok_pkg::TK_BAD_STR;
                pltok_pkg::M_SLASH: close_uch  = pltok_pkg::CH_SLASH;
                pltok_pkg::M_LT:    close_kind = pltok_pkg::TK_LT;
                pltok_pkg::M_GT:    close_kind = pltok_pkg::TK_GT;
                pltok_pkg::M_EQ:    close_uch  = pltok_pkg::CH_EQUAL;
                pltok_pkg::M_BANG:  close_uch  = pltok_pkg::CH_BANG;
                default:            close_v    = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                pltok_pkg::M_IDENT:
                begin
                    if (!pltok_pkg::is_word(c))
                    begin
                        close_v    = 1'b1;
                        close_kind = ident_kind;
                        restart    = 1'b1;
                    end
                end
                pltok_pkg::M_INT,
                pltok_pkg::M_FRAC:
                begin
                    if (!pltok_pkg::is_digit(c) &&
                        !(c == pltok_pkg::CH_DOT && mode_reg == pltok_pkg::M_INT))
                    begin
                        close_v    = 1'b1;
                        close_kind = pltok_pkg::TK_NUMBER;
                        restart    = 1'b1;
                    end
                end
                pltok_pkg::M_STR:
                begin
                    if (c == pltok_pkg::CH_QUOTE)
                    begin
                        close_v    = 1'b1;
                        close_kind = pltok_pkg::TK_STRING;
                    end
                    else if (c == pltok_pkg::CH_NL)
                    begin
                        close_v    = 1'b1;
                        close_kind = pltok_pkg::TK_BAD_STR;
                    end
                end
                pltok_pkg::M_SLASH:
                begin
                    if (c != pltok_pkg::CH_SLASH && c != pltok_pkg::CH_STAR)
                    begin
                        close_v   = 1'b1;
                        close_uch = pltok_pkg::CH_SLASH;
                        restart   = 1'b1;
                    end
                end
                pltok_pkg::M_LT,
                pltok_pkg::M_GT,
                pltok_pkg::M_EQ,
                pltok_pkg::M_BANG:
                begin
                    close_v    = 1'b1;
                    close_pair = (c == pltok_pkg::CH_EQUAL);
                    restart    = !close_pair;
                    case (mode_reg)
                        pltok_pkg::M_LT:
                            close_kind = close_pair ? pltok_pkg::TK_LE : pltok_pkg::TK_LT;
                        pltok_pkg::M_GT:
                            close_kind = close_pair ? pltok_pkg::TK_GE : pltok_pkg::TK_GT;
                        pltok_pkg::M_EQ:
                        begin
                            close_kind = close_pair ? pltok_pkg::TK_EQ_EQ
                                                    : pltok_pkg::TK_UNKNOWN;
                            close_uch  = close_pair ? pltok_pkg::CH_NUL
                                                    : pltok_pkg::CH_EQUAL;
                        end
                        default:
                        begin
                            close_kind = close_pair ? pltok_pkg::TK_NE
                                                    : pltok_pkg::TK_UNKNOWN;
                            close_uch  = close_pair ? pltok_pkg::CH_NUL
                                                    : pltok_pkg::CH_BANG;
                        end
                    endcase
                end
                pltok_pkg::M_LCOM,
                pltok_pkg::M_BCOM,
                pltok_pkg::M_BSTAR: ;
                default:
                    restart = 1'b1;
            endcase
        end
    end

    // Classes of a rescanned byte
    logic c_space, c_opens;
    assign c_space = pltok_pkg::is_space(c);
    // Bytes that are skipped or open a pending token rather than emitting at once
    assign c_opens = c_space || c == pltok_pkg::CH_QUOTE || pltok_pkg::is_word(c) ||
                     c == pltok_pkg::CH_SLASH || c == pltok_pkg::CH_LESS ||
                     c == pltok_pkg::CH_GREAT || c == pltok_pkg::CH_EQUAL ||
                     c == pltok_pkg::CH_BANG;

    logic [POS_WIDTH-1:0]    line_inc, col_inc;
    logic [OFFSET_WIDTH-1:0] off_inc;
    logic [15:0]             len_inc;
    assign line_inc = (&cur_line_reg) ? cur_line_reg : cur_line_reg + 1'b1;
    assign col_inc  = (&cur_col_reg) ? cur_col_reg : cur_col_reg + 1'b1;
    assign off_inc  = (&cur_off_reg) ? cur_off_reg : cur_off_reg + 1'b1;
    assign len_inc  = (tok_len_reg == pltok_pkg::LEN_MAX) ? tok_len_reg : tok_len_reg + 1'b1;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        cur_off_next  = cur_off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        tok_len_next  = tok_len_reg;
        ident_next    = ident_reg;
        too_long_next = too_long_reg;

        if (is_eos)
        begin
            // Back to the start of a new source
            mode_next     = pltok_pkg::M_SKIP;
            cur_line_next = POS_WIDTH'(1);
            cur_col_next  = POS_WIDTH'(1);
            cur_off_next  = '0;
        end
        else
        begin
            case (mode_reg)
                pltok_pkg::M_IDENT:
                begin
                    if (!restart)
                    begin
                        if (tok_len_reg < 16'(KEYWORD_MAX_LEN))
                        begin
                            ident_next[tok_len_reg[IDX_W-1:0]] = c;
                        end
                        else
                        begin
                            too_long_next = 1'b1;
                        end
                        tok_len_next = len_inc;
                    end
                end
                pltok_pkg::M_INT,
                pltok_pkg::M_FRAC:
                begin
                    if (!restart)
                    begin
                        tok_len_next = len_inc;
                        if (c == pltok_pkg::CH_DOT)
                        begin
                            mode_next = pltok_pkg::M_FRAC;
                        end
                    end
                end
                pltok_pkg::M_STR:
                begin
                    if (close_v)
                    begin
                        mode_next = pltok_pkg::M_SKIP;
                    end
                    else
                    begin
                        tok_len_next = len_inc;
                    end
                end
                pltok_pkg::M_SLASH:
                begin
                    if (c == pltok_pkg::CH_SLASH)
                    begin
                        mode_next = pltok_pkg::M_LCOM;
                    end
                    else if (c == pltok_pkg::CH_STAR)
                    begin
                        mode_next = pltok_pkg::M_BCOM;
                    end
                end
                pltok_pkg::M_LCOM:
                begin
                    if (c == pltok_pkg::CH_NL)
                    begin
                        mode_next = pltok_pkg::M_SKIP;
                    end
                end
                pltok_pkg::M_BCOM:
                begin
                    if (c == pltok_pkg::CH_STAR)
                    begin
                        mode_next = pltok_pkg::M_BSTAR;
                    end
                end
                pltok_pkg::M_BSTAR:
                begin
                    if (c == pltok_pkg::CH_SLASH)
                    begin
                        mode_next = pltok_pkg::M_SKIP;
                    end
                    else if (c != pltok_pkg::CH_STAR)
                    begin
                        mode_next = pltok_pkg::M_BCOM;
                    end
                end
                default:
                begin
                    // Operator pair completed; lone characters rescan below
                    if (close_pair)
                    begin
                        mode_next = pltok_pkg::M_SKIP;
                    end
                end
            endcase

            if (restart)
            begin
                mode_next     = pltok_pkg::M_SKIP;
                tok_line_next = cur_line_reg;
                tok_col_next  = cur_col_reg;
                tok_off_next  = cur_off_reg;
                tok_len_next  = 16'd1;
                if (c == pltok_pkg::CH_QUOTE)
                begin
                    // String value starts after the quote
                    mode_next    = pltok_pkg::M_STR;
                    tok_off_next = off_inc;
                    tok_len_next = '0;
                end
                else if (pltok_pkg::is_digit(c))
                begin
                    mode_next = pltok_pkg::M_INT;
                end
                else if (pltok_pkg::is_word(c))
                begin
                    mode_next = pltok_pkg::M_IDENT;
                    for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                    begin
                        ident_next[i] = pltok_pkg::CH_NUL;
                    end
                    ident_next[0] = c;
                    too_long_next = 1'b0;
                end
                else if (c == pltok_pkg::CH_SLASH)
                begin
                    mode_next = pltok_pkg::M_SLASH;
                end
                else if (c == pltok_pkg::CH_LESS)
                begin
                    mode_next = pltok_pkg::M_LT;
                end
                else if (c == pltok_pkg::CH_GREAT)
                begin
                    mode_next = pltok_pkg::M_GT;
                end
                else if (c == pltok_pkg::CH_EQUAL)
                begin
                    mode_next = pltok_pkg::M_EQ;
                end
                else if (c == pltok_pkg::CH_BANG)
                begin
                    mode_next = pltok_pkg::M_BANG;
                end
            end

            // Position tracking, saturating
            if (c == pltok_pkg::CH_NL)
            begin
                cur_line_next = line_inc;
                cur_col_next  = POS_WIDTH'(1);
            end
            else
            begin
                cur_col_next = col_inc;
            end
            cur_off_next = off_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pltok_pkg::M_SKIP;
            cur_line_reg <= POS_WIDTH'(1);
            cur_col_reg  <= POS_WIDTH'(1);
            cur_off_reg  <= '0;
        end
        else if (go)
        begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            cur_off_reg  <= cur_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            tok_len_reg  <= tok_len_next;
            ident_reg    <= ident_next;
            too_long_reg <= too_long_next;
        end
    end

    // ------------------------------------------------------------------
    // Outputs of the decode stage: up to two tokens, pending one first.
    // The second comes from a rescanned byte that is a token by itself,
    // or is the end-of-file token.
    // ------------------------------------------------------------------
    logic                    sec_v;
    logic [4:0]              sec_kind;
    logic [15:0]             sec_len;
    logic [7:0]              sec_uch;

    logic [1:0]              push_n;
    logic [4:0]              slot_kind [2];
    logic [POS_WIDTH-1:0]    slot_line [2];
    logic [POS_WIDTH-1:0]    slot_col  [2];
    logic [OFFSET_WIDTH-1:0] slot_off  [2];
    logic [15:0]             slot_len  [2];
    logic [7:0]              slot_uch  [2];
    logic                    slot_last [2];

    always_comb
    begin
        sec_v    = 1'b0;
        sec_kind = pltok_pkg::TK_EOF;
        sec_len  = '0;
        sec_uch  = pltok_pkg::CH_NUL;
        if (is_eos)
        begin
            sec_v = 1'b1;
        end
        else if (restart && !c_opens)
        begin
            sec_v   = 1'b1;
            sec_len = 16'd1;
            if (c == pltok_pkg::CH_SEMI)
            begin
                sec_kind = pltok_pkg::TK_SEMI;
            end
            else
            begin
                sec_kind = pltok_pkg::TK_UNKNOWN;
                sec_uch  = c;
            end
        end
    end

    always_comb
    begin
        push_n = go ? (2'(close_v) + 2'(sec_v)) : 2'd0;

        // Slot 1 always carries the second token when both are present
        slot_kind[1] = sec_kind;
        slot_line[1] = cur_line_reg;
        slot_col[1]  = cur_col_reg;
        slot_off[1]  = cur_off_reg;
        slot_len[1]  = sec_len;
        slot_uch[1]  = sec_uch;
        slot_last[1] = 1'b1;

        if (close_v)
        begin
            slot_kind[0] = close_kind;
            slot_line[0] = tok_line_reg;
            slot_col[0]  = tok_col_reg;
            slot_off[0]  = tok_off_reg;
            slot_len[0]  = close_pair ? 16'd2 : tok_len_reg;
            slot_uch[0]  = close_uch;
            slot_last[0] = !sec_v;
        end
        else
        begin
            slot_kind[0] = sec_kind;
            slot_line[0] = cur_line_reg;
            slot_col[0]  = cur_col_reg;
            slot_off[0]  = cur_off_reg;
            slot_len[0]  = sec_len;
            slot_uch[0]  = sec_uch;
            slot_last[0] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: register stage between decode and the token channel
    // ------------------------------------------------------------------
    logic [4:0]              q_kind [pltok_pkg::OQ_DEPTH];
    logic [POS_WIDTH-1:0]    q_line [pltok_pkg::OQ_DEPTH];
    logic [POS_WIDTH-1:0]    q_col  [pltok_pkg::OQ_DEPTH];
    logic [OFFSET_WIDTH-1:0] q_off  [pltok_pkg::OQ_DEPTH];
    logic [15:0]             q_len  [pltok_pkg::OQ_DEPTH];
    logic [7:0]              q_uch  [pltok_pkg::OQ_DEPTH];
    logic                    q_last [pltok_pkg::OQ_DEPTH];

    logic [pltok_pkg::OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pltok_pkg::OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pltok_pkg::OQ_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + pltok_pkg::OQ_AW'(pop);
        count_next  = count_reg + pltok_pkg::OQ_CW'(push_n) - pltok_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < 2; s++)
        begin
            if (push_n > 2'(s))
            begin
                q_kind[wr_ptr_reg + pltok_pkg::OQ_AW'(s)] <= slot_kind[s];
                q_line[wr_ptr_reg + pltok_pkg::OQ_AW'(s)] <= slot_line[s];
                q_col[wr_ptr_reg + pltok_pkg::OQ_AW'(s)]  <= slot_col[s];
                q_off[wr_ptr_reg + pltok_pkg::OQ_AW'(s)]  <= slot_off[s];
                q_len[wr_ptr_reg + pltok_pkg::OQ_AW'(s)]  <= slot_len[s];
                q_uch[wr_ptr_reg + pltok_pkg::OQ_AW'(s)]  <= slot_uch[s];
                q_last[wr_ptr_reg + pltok_pkg::OQ_AW'(s)] <= slot_last[s];
            end
        end
    end

    assign tok_kind     = q_kind[rd_ptr_reg];
    assign start_line   = q_line[rd_ptr_reg];
    assign start_column = q_col[rd_ptr_reg];
    assign value_offset = q_off[rd_ptr_reg];
    assign value_length = q_len[rd_ptr_reg];
    assign unknown_char = q_uch[rd_ptr_reg];
    assign last_of_run  = q_last[rd_ptr_reg];

endmodule

// ===== tb/tb_policy_language_tokenizer_unit.sv =====
// Self-checking testbench for the policy-language tokenizer unit.
module tb_policy_language_tokenizer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Saturation limits of the position counters at the default widths
    localparam logic [15:0] POS_LIMIT = 16'hFFFF;
    localparam logic [23:0] OFF_LIMIT = 24'hFFFFFF;
    localparam int          WORD_MAX  = pltok_pkg::KEYWORD_MAX_LEN_DEF;

    // One source transfer: a byte or an end-of-source marker
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } src_item_t;

    // One token as it leaves the block
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [23:0] off;
        logic [15:0] len;
        logic [7:0]  uch;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = pltok_pkg::CMD_BYTE;
    logic [7:0]  src_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  tok_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [23:0] value_offset;
    logic [15:0] value_length;
    logic [7:0]  unknown_char;
    logic        last_of_run;

    policy_language_tokenizer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .src_byte     (src_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tok_kind     (tok_kind),
        .start_line   (start_line),
        .start_column (start_column),
        .value_offset (value_offset),
        .value_length (value_length),
        .unknown_char (unknown_char),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Source bytes waiting to be driven, and tokens the block still owes us
    src_item_t byte_feed [$];
    token_t    pending_tokens [$];

    int  mismatch_count = 0;
    int  queued_items = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  src_fire = 1'b0;
    // Fast mode: no idling on either side, sink always ready
    bit  fast_mode = 1'b0;

    string kw_names [pltok_pkg::KW_COUNT] = '{
        "ALLOW", "DENY", "ROLE", "ACTION", "ON", "RESOURCE", "WHERE", "AND",
        "OR", "NOT", "TRUE", "FALSE", "ip", "time", "mfa", "region", "tag"
    };

    // ------------------------------------------------------------------
    // Lexer state as the predictor sees it
    // ------------------------------------------------------------------
    pltok_pkg::scan_mode_t lex_mode;
    logic [15:0] pos_line;
    logic [15:0] pos_col;
    logic [23:0] pos_off;
    logic [15:0] tk_line;
    logic [15:0] tk_col;
    logic [23:0] tk_off;
    logic [15:0] tk_len;
    logic [7:0]  word_buf [WORD_MAX];
    logic        word_long;

    function automatic bit ws_char(input logic [7:0] c);
        return (c == pltok_pkg::CH_SPACE) ||
               (c >= pltok_pkg::CH_TAB && c <= pltok_pkg::CH_CR);
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= pltok_pkg::CH_0 && c <= pltok_pkg::CH_9;
    endfunction

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= pltok_pkg::CH_LC_A && c <= pltok_pkg::CH_LC_Z) ||
               (c >= pltok_pkg::CH_UC_A && c <= pltok_pkg::CH_UC_Z);
    endfunction

    task automatic lexer_clear();
        lex_mode  = pltok_pkg::M_SKIP;
        pos_line  = 16'd1;
        pos_col   = 16'd1;
        pos_off   = 24'd0;
        tk_line   = 16'd1;
        tk_col    = 16'd1;
        tk_off    = 24'd0;
        tk_len    = 16'd0;
        word_long = 1'b0;
        for (int i = 0; i < WORD_MAX; i++)
            word_buf[i] = 8'h00;
    endtask

    // Keyword lookup; anything longer than the table's longest word is plain
    function automatic logic [4:0] word_kind();
        logic [4:0] kind;
        bit         hit;
        kind = pltok_pkg::TK_UNKNOWN;
        if (!word_long)
        begin
            for (int k = 0; k < pltok_pkg::KW_COUNT; k++)
            begin
                if (tk_len == 16'(kw_names[k].len()))
                begin
                    hit = 1'b1;
                    for (int j = 0; j < kw_names[k].len(); j++)
                        if (word_buf[j] != kw_names[k][j])
                            hit = 1'b0;
                    if (hit)
                        kind = pltok_pkg::TK_KW_BASE + 5'(k);
                end
            end
        end
        return kind;
    endfunction

    task automatic note_tok(input logic [4:0] kind, input logic [15:0] line,
                            input logic [15:0] col, input logic [23:0] off,
                            input logic [15:0] len, input logic [7:0] uch);
        token_t t;
        t = '{kind, line, col, off, len, uch, 1'b0};
        pending_tokens = {pending_tokens, t};
    endtask

    task automatic note_open(input logic [4:0] kind, input logic [7:0] uch);
        note_tok(kind, tk_line, tk_col, tk_off, tk_len, uch);
    endtask

    task automatic mark_start(input logic [15:0] len);
        tk_line = pos_line;
        tk_col  = pos_col;
        tk_off  = pos_off;
        tk_len  = len;
    endtask

    task automatic grow_len();
        if (tk_len < pltok_pkg::LEN_MAX)
            tk_len = tk_len + 16'd1;
    endtask

    // First byte of a token, or a byte seen while skipping
    task automatic open_token(input logic [7:0] c);
        lex_mode = pltok_pkg::M_SKIP;
        if (ws_char(c))
        begin
            // nothing to do
        end
        else if (c == pltok_pkg::CH_QUOTE)
        begin
            mark_start(16'd0);
            tk_off   = (pos_off < OFF_LIMIT) ? pos_off + 24'd1 : OFF_LIMIT;
            lex_mode = pltok_pkg::M_STR;
        end
        else if (digit_char(c))
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_INT;
        end
        else if (letter_char(c) || c == pltok_pkg::CH_UNDER)
        begin
            mark_start(16'd1);
            for (int i = 0; i < WORD_MAX; i++)
                word_buf[i] = 8'h00;
            word_buf[0] = c;
            word_long   = 1'b0;
            lex_mode    = pltok_pkg::M_IDENT;
        end
        else if (c == pltok_pkg::CH_SLASH)
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_SLASH;
        end
        else if (c == pltok_pkg::CH_LESS)
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_LT;
        end
        else if (c == pltok_pkg::CH_GREAT)
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_GT;
        end
        else if (c == pltok_pkg::CH_EQUAL)
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_EQ;
        end
        else if (c == pltok_pkg::CH_BANG)
        begin
            mark_start(16'd1);
            lex_mode = pltok_pkg::M_BANG;
        end
        else if (c == pltok_pkg::CH_SEMI)
        begin
            note_tok(pltok_pkg::TK_SEMI, pos_line, pos_col, pos_off, 16'd1, 8'h00);
        end
        else
        begin
            note_tok(pltok_pkg::TK_UNKNOWN, pos_line, pos_col, pos_off, 16'd1, c);
        end
    endtask

    // Held operator character: pairs with '=' or goes out alone
    task automatic pair_or_single(input logic [7:0] c, input logic [4:0] pair_kind,
                                  input logic [4:0] single_kind, input logic [7:0] uch);
        if (c == pltok_pkg::CH_EQUAL)
        begin
            tk_len = 16'd2;
            note_open(pair_kind, 8'h00);
            lex_mode = pltok_pkg::M_SKIP;
        end
        else
        begin
            note_open(single_kind, uch);
            open_token(c);
        end
    endtask

    // End of source: whatever is open goes out first
    task automatic flush_open();
        case (lex_mode)
            pltok_pkg::M_IDENT: note_open(word_kind(), 8'h00);
            pltok_pkg::M_INT,
            pltok_pkg::M_FRAC:  note_open(pltok_pkg::TK_NUMBER, 8'h00);
            pltok_pkg::M_STR:   note_open(pltok_pkg::TK_BAD_STR, 8'h00);
            pltok_pkg::M_SLASH: note_open(pltok_pkg::TK_UNKNOWN, pltok_pkg::CH_SLASH);
            pltok_pkg::M_LT:    note_open(pltok_pkg::TK_LT, 8'h00);
            pltok_pkg::M_GT:    note_open(pltok_pkg::TK_GT, 8'h00);
            pltok_pkg::M_EQ:    note_open(pltok_pkg::TK_UNKNOWN, pltok_pkg::CH_EQUAL);
            pltok_pkg::M_BANG:  note_open(pltok_pkg::TK_UNKNOWN, pltok_pkg::CH_BANG);
            default:            ;
        endcase
    endtask

    task automatic lex_byte(input logic [7:0] c);
        case (lex_mode)
            pltok_pkg::M_IDENT:
            begin
                if (letter_char(c) || digit_char(c) || c == pltok_pkg::CH_UNDER)
                begin
                    if (tk_len < WORD_MAX)
                        word_buf[tk_len] = c;
                    else
                        word_long = 1'b1;
                    grow_len();
                end
                else
                begin
                    note_open(word_kind(), 8'h00);
                    open_token(c);
                end
            end
            pltok_pkg::M_INT,
            pltok_pkg::M_FRAC:
            begin
                if (digit_char(c))
                begin
                    grow_len();
                end
                else if (c == pltok_pkg::CH_DOT && lex_mode == pltok_pkg::M_INT)
                begin
                    grow_len();
                    lex_mode = pltok_pkg::M_FRAC;
                end
                else
                begin
                    note_open(pltok_pkg::TK_NUMBER, 8'h00);
                    open_token(c);
                end
            end
            pltok_pkg::M_STR:
            begin
                if (c == pltok_pkg::CH_QUOTE)
                begin
                    note_open(pltok_pkg::TK_STRING, 8'h00);
                    lex_mode = pltok_pkg::M_SKIP;
                end
                else if (c == pltok_pkg::CH_NL)
                begin
                    note_open(pltok_pkg::TK_BAD_STR, 8'h00);
                    lex_mode = pltok_pkg::M_SKIP;
                end
                else
                begin
                    grow_len();
                end
            end
            pltok_pkg::M_SLASH:
            begin
                if (c == pltok_pkg::CH_SLASH)
                    lex_mode = pltok_pkg::M_LCOM;
                else if (c == pltok_pkg::CH_STAR)
                    lex_mode = pltok_pkg::M_BCOM;
                else
                begin
                    note_open(pltok_pkg::TK_UNKNOWN, pltok_pkg::CH_SLASH);
                    open_token(c);
                end
            end
            pltok_pkg::M_LCOM:
                if (c == pltok_pkg::CH_NL) lex_mode = pltok_pkg::M_SKIP;
            pltok_pkg::M_BCOM:
                if (c == pltok_pkg::CH_STAR) lex_mode = pltok_pkg::M_BSTAR;
            pltok_pkg::M_BSTAR:
            begin
                if (c == pltok_pkg::CH_SLASH)
                    lex_mode = pltok_pkg::M_SKIP;
                else if (c != pltok_pkg::CH_STAR)
                    lex_mode = pltok_pkg::M_BCOM;
            end
            pltok_pkg::M_LT:
                pair_or_single(c, pltok_pkg::TK_LE, pltok_pkg::TK_LT, 8'h00);
            pltok_pkg::M_GT:
                pair_or_single(c, pltok_pkg::TK_GE, pltok_pkg::TK_GT, 8'h00);
            pltok_pkg::M_EQ:
                pair_or_single(c, pltok_pkg::TK_EQ_EQ, pltok_pkg::TK_UNKNOWN,
                               pltok_pkg::CH_EQUAL);
            pltok_pkg::M_BANG:
                pair_or_single(c, pltok_pkg::TK_NE, pltok_pkg::TK_UNKNOWN,
                               pltok_pkg::CH_BANG);
            default:
                open_token(c);
        endcase

        // Position advances after the byte is classified; all counters saturate
        if (c == pltok_pkg::CH_NL)
        begin
            if (pos_line < POS_LIMIT)
                pos_line = pos_line + 16'd1;
            pos_col = 16'd1;
        end
        else if (pos_col < POS_LIMIT)
        begin
            pos_col = pos_col + 16'd1;
        end
        if (pos_off < OFF_LIMIT)
            pos_off = pos_off + 24'd1;
    endtask

    // Predict every token caused by one accepted source transfer
    task automatic lex_item(input logic is_eos, input logic [7:0] c);
        int     before_n;
        int     last_i;
        token_t t;
        before_n = pending_tokens.size();
        if (is_eos == pltok_pkg::CMD_EOS)
        begin
            flush_open();
            note_tok(pltok_pkg::TK_EOF, pos_line, pos_col, pos_off, 16'd0, 8'h00);
            lexer_clear();
        end
        else
        begin
            lex_byte(c);
        end
        // The last token of this transfer carries the run marker
        if (pending_tokens.size() > before_n)
        begin
            last_i = pending_tokens.size() - 1;
            t = pending_tokens[last_i];
            t.last = 1'b1;
            pending_tokens[last_i] = t;
        end
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (fast_mode || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Source driver: changes on the falling edge, holds until the transfer
    always @(negedge clk)
    begin
        src_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !src_fire)
            begin
                // still waiting for in_ready; payload stays put
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (byte_feed.size() > 0)
            begin
                nxt = byte_feed.pop_front();
                in_valid <= 1'b1;
                cmd      <= nxt.cmd;
                src_byte <= nxt.data;
                gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Token sink back-pressure
    always @(negedge clk)
    begin
        if (fast_mode)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    function automatic bit field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Monitor and predictor, both on the rising edge. A token never leaves
    // in the same cycle as the byte that causes it, so checking first is safe.
    always @(posedge clk)
    begin
        token_t want;
        src_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $error("token with no expectation: kind %0d at %0d:%0d",
                           tok_kind, start_line, start_column);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (field_bad("tok_kind", 32'(want.kind), 32'(tok_kind)) |
                        field_bad("start_line", 32'(want.line), 32'(start_line)) |
                        field_bad("start_column", 32'(want.col), 32'(start_column)) |
                        field_bad("value_offset", 32'(want.off), 32'(value_offset)) |
                        field_bad("value_length", 32'(want.len), 32'(value_length)) |
                        field_bad("unknown_char", 32'(want.uch), 32'(unknown_char)) |
                        field_bad("last_of_run", 32'(want.last), 32'(last_of_run)))
                        mismatch_count++;
                end
            end
            if (in_valid && in_ready)
                lex_item(cmd, src_byte);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        src_item_t it;
        it.cmd  = pltok_pkg::CMD_BYTE;
        it.data = b;
        byte_feed = {byte_feed, it};
        queued_items++;
    endtask

    task automatic add_eos();
        src_item_t it;
        it.cmd  = pltok_pkg::CMD_EOS;
        it.data = 8'($urandom_range(0, 255));
        byte_feed = {byte_feed, it};
        queued_items++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_space();
        logic [7:0] set [6] = '{pltok_pkg::CH_SPACE, pltok_pkg::CH_TAB, pltok_pkg::CH_NL,
                                8'h0B, 8'h0C, pltok_pkg::CH_CR};
        return set[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] pick_word_char();
        string set;
        set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // One lexeme of a policy text, mostly well formed, some of it noise
    task automatic add_lexeme();
        int    r;
        int    n;
        string kw;
        string ops [9] = '{"==", "!=", "<=", ">=", "<", ">", "=", "!", "/"};
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 14)
        begin
            add_text(kw_names[$urandom_range(0, pltok_pkg::KW_COUNT - 1)]);
        end
        else if (r < 19)
        begin
            // near misses: prefix, extension past the table, wrong case
            kw = kw_names[$urandom_range(0, pltok_pkg::KW_COUNT - 1)];
            case ($urandom_range(0, 2))
                0: add_text(kw.substr(0, kw.len() - 2));
                1:
                begin
                    add_text(kw);
                    add_byte(pick_word_char());
                end
                default: add_text(kw.tolower() == kw ? kw.toupper() : kw.tolower());
            endcase
        end
        else if (r < 27)
        begin
            add_byte($urandom_range(0, 1)
                     ? 8'($urandom_range(pltok_pkg::CH_LC_A, pltok_pkg::CH_LC_Z))
                     : pltok_pkg::CH_UNDER);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
            repeat (n) add_byte(pick_word_char());
        end
        else if (r < 36)
        begin
            repeat ($urandom_range(1, 4))
                add_byte(8'($urandom_range(pltok_pkg::CH_0, pltok_pkg::CH_9)));
            if ($urandom_range(0, 1))
            begin
                add_byte(pltok_pkg::CH_DOT);
                repeat ($urandom_range(0, 3))
                    add_byte(8'($urandom_range(pltok_pkg::CH_0, pltok_pkg::CH_9)));
                if ($urandom_range(0, 5) == 0)
                    add_byte(pltok_pkg::CH_DOT);
            end
        end
        else if (r < 45)
        begin
            add_byte(pltok_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == pltok_pkg::CH_QUOTE || b == pltok_pkg::CH_NL)
                    b = 8'h61;
                add_byte(b);
            end
            add_byte(($urandom_range(0, 6) == 0) ? pltok_pkg::CH_NL : pltok_pkg::CH_QUOTE);
        end
        else if (r < 60)
        begin
            add_text(ops[$urandom_range(0, 8)]);
        end
        else if (r < 66)
        begin
            add_byte(pltok_pkg::CH_SEMI);
        end
        else if (r < 71)
        begin
            add_text("//");
            repeat ($urandom_range(0, 5))
            begin
                b = 8'($urandom_range(0, 255));
                add_byte(b == pltok_pkg::CH_NL ? pltok_pkg::CH_STAR : b);
            end
            add_byte(pltok_pkg::CH_NL);
        end
        else if (r < 76)
        begin
            add_text("/*");
            repeat ($urandom_range(0, 5))
                add_byte($urandom_range(0, 2) == 0 ? pltok_pkg::CH_STAR
                                                   : 8'($urandom_range(0, 255)));
            add_text($urandom_range(0, 1) ? "**/" : "*/");
        end
        else if (r < 86)
        begin
            add_byte(pick_space());
        end
        else if (r < 97)
        begin
            add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_eos();
        end
        if ($urandom_range(0, 9) < 7)
            add_byte(pick_space());
    endtask

    // Sender stops until every owed token has arrived
    task automatic drain();
        while (byte_feed.size() > 0 || in_valid)
            @(posedge clk);
        while (pending_tokens.size() > 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        lexer_clear();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: keyword, pair operator, number with empty fraction,
        // semicolon, string broken by newline, lone slash, bang-equals,
        // NUL and top byte as unknowns, lone '>' flushed at end of source,
        // unterminated comment and unterminated string at end of source.
        add_text("ip<=9.;");
        add_byte(pltok_pkg::CH_QUOTE);
        add_byte(8'h71);
        add_byte(pltok_pkg::CH_NL);
        add_text("/!=");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("a>");
        add_eos();
        add_text("/*");
        add_eos();
        add_byte(pltok_pkg::CH_QUOTE);
        add_byte(8'h73);
        add_eos();
        drain();

        // Random policy text in three bursts, each closed by end of source
        for (int phase = 0; phase < 3; phase++)
        begin
            queued_items = 0;
            while (queued_items < 150)
                add_lexeme();
            add_eos();
            drain();
        end

        // Let any stray token show up with the sink always ready
        fast_mode = 1'b1;
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
